[rtl/mmuf_pkg.sv]
package mmuf_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;

    // slope path widths
    localparam int DIFF_W  = DATA_W + 1;
    localparam int SLOPE_W = DIFF_W + 2;
    localparam int SUM_W   = DIFF_W + 3;
    localparam int HALF_W  = SUM_W - 1;
    localparam int U_W     = SUM_W;
    localparam int PHI_W   = U_W + 1;

    // divide by three, two bits a step
    localparam int DIV_DIGITS       = U_W / 2;
    localparam int DIV_STAGES       = 3;
    localparam int DIGITS_PER_STAGE = DIV_DIGITS / DIV_STAGES;

    // flux path widths
    localparam int PROD_W  = 2 * DATA_W;
    localparam int RND_W   = PROD_W + 1;
    localparam int SHIFT_W = RND_W - FRAC_BITS;

    localparam logic signed [SUM_W-1:0] ROUND_SIX  = SUM_W'(3);
    localparam logic [U_W-1:0]          U_OFFSET   = U_W'(3) << (HALF_W - 1);
    localparam logic signed [PHI_W-1:0] Q_OFFSET   = PHI_W'(1) << (HALF_W - 1);
    localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SLOPE_W-1:0] slope_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [U_W-1:0] u;
        data_t          y;
        data_t          uf;
    } slope_word_t;

    typedef struct packed {
        logic [U_W-1:0] q;
        data_t          y;
        data_t          uf;
    } quot_word_t;

    // minmod of a slope against a scaled neighbour slope
    function automatic diff_t minmod(input diff_t x, input slope_t y);
        slope_t xe;
        diff_t  r;
        xe = SLOPE_W'(x);
        r  = '0;
        if (x > 0)
        begin
            if (y > 0)
                r = (xe < y) ? x : DIFF_W'(y);
        end
        else if (x < 0)
        begin
            if (y < 0)
                r = (xe > y) ? x : DIFF_W'(y);
        end
        return r;
    endfunction

    // one radix-4 step of division by three: returns {quotient digit, remainder}
    function automatic logic [3:0] div3_digit(input logic [1:0] rem, input logic [1:0] dig);
        logic [3:0] t;
        logic [1:0] q;
        logic [3:0] r;
        t = {rem, dig};
        if (t >= 4'd9)
            q = 2'd3;
        else if (t >= 4'd6)
            q = 2'd2;
        else if (t >= 4'd3)
            q = 2'd1;
        else
            q = 2'd0;
        r = t - ((4'(q) << 1) + 4'(q));
        return {q, r[1:0]};
    endfunction

endpackage

[rtl/muscl_minmod_upwind_face_flux_core.sv]
// MUSCL face flux, kappa one third, minmod limited, upwind on the rebuilt state.
// Input channel: cell_valid / cell_stall carries one word of four cell values
// around a face (a b | c d) and the face velocity, all signed Q16.16.
// Output channel: flux_valid / flux_stall carries the flux word, saturated to
// 32 bits, with saturated set when the flux was clipped.
// An accepted input word passes through registered stages of stencil select,
// slopes and limiter, divide by three (six radix-4 digits a stage), then
// state rebuild, 32x32 multiply and rounding with clipping, each registered.
// Throughput is one word a cycle when the output is not stalled, set by the
// fully pipelined datapath.
// Each stage holds its own valid bit and advances when it is empty or the
// next stage advances, so bubbles close up under stall. While flux_stall is
// high the output word holds, the pipe fills, and cell_stall rises once
// every stage holds a word; no word is lost or repeated.
// Reset (rst_n low, asynchronous) empties the pipe; cell_stall is low out of
// reset, so the first word can be taken as soon as rst_n is released.
module muscl_minmod_upwind_face_flux_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cell_valid,
    output logic            cell_stall,
    input  mmuf_pkg::data_t cell_a,
    input  mmuf_pkg::data_t cell_b,
    input  mmuf_pkg::data_t cell_c,
    input  mmuf_pkg::data_t cell_d,
    input  mmuf_pkg::data_t face_velocity,
    output logic            flux_valid,
    input  logic            flux_stall,
    output mmuf_pkg::data_t face_flux,
    output logic            saturated
);

    logic                  slope_in_ready;
    logic                  slope_valid, slope_ready;
    mmuf_pkg::slope_word_t slope_word;
    logic                  quot_valid, quot_ready;
    mmuf_pkg::quot_word_t  quot_word;

    assign cell_stall = !slope_in_ready;

    mmuf_slope u_slope (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (cell_valid),
        .in_ready      (slope_in_ready),
        .cell_a        (cell_a),
        .cell_b        (cell_b),
        .cell_c        (cell_c),
        .cell_d        (cell_d),
        .face_velocity (face_velocity),
        .out_valid     (slope_valid),
        .out_ready     (slope_ready),
        .out_word      (slope_word)
    );

    mmuf_div3 u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slope_valid),
        .in_ready  (slope_ready),
        .in_word   (slope_word),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_word  (quot_word)
    );

    mmuf_flux u_flux (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (quot_valid),
        .in_ready   (quot_ready),
        .in_word    (quot_word),
        .flux_valid (flux_valid),
        .flux_stall (flux_stall),
        .face_flux  (face_flux),
        .saturated  (saturated)
    );

    // a clipped word carries one of the two bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (flux_valid && saturated) |->
            (face_flux == mmuf_pkg::DATA_MAX || face_flux == mmuf_pkg::DATA_MIN))
        else $error("saturated flux is not at a bound");

    // with the output free the whole pipe advances and takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !flux_stall |-> !cell_stall)
        else $error("input stalled while output is free");

    // the pipe comes out of reset empty
    assert property (@(posedge clk)
        $rose(rst_n) |-> !flux_valid)
        else $error("flux word present straight after reset");

endmodule

[rtl/mmuf_slope.sv]
module mmuf_slope (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mmuf_pkg::data_t       cell_a,
    input  mmuf_pkg::data_t       cell_b,
    input  mmuf_pkg::data_t       cell_c,
    input  mmuf_pkg::data_t       cell_d,
    input  mmuf_pkg::data_t       face_velocity,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mmuf_pkg::slope_word_t out_word
);

    logic adv1, adv2, adv3;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    mmuf_pkg::diff_t       s1_dp_reg, s1_dm_reg, s1_dp_next, s1_dm_next;
    mmuf_pkg::data_t       s1_y_reg, s1_uf_reg, s1_y_next;
    mmuf_pkg::diff_t       s2_dp_reg, s2_dm_reg, s2_dp_next, s2_dm_next;
    mmuf_pkg::data_t       s2_y_reg, s2_uf_reg;
    logic [mmuf_pkg::U_W-1:0] s3_u_reg, s3_u_next;
    mmuf_pkg::data_t       s3_y_reg, s3_uf_reg;

    logic signed [mmuf_pkg::SUM_W-1:0] sum6;
    logic signed [mmuf_pkg::HALF_W-1:0] half6;
    mmuf_pkg::data_t sel_x, sel_z;

    assign adv3     = !s3_valid_reg || out_ready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // mirror the stencil for negative velocity so one path serves both states
    always_comb
    begin
        if (face_velocity[mmuf_pkg::DATA_W-1])
        begin
            sel_x     = cell_d;
            s1_y_next = cell_c;
            sel_z     = cell_b;
        end
        else
        begin
            sel_x     = cell_a;
            s1_y_next = cell_b;
            sel_z     = cell_c;
        end
        s1_dp_next = mmuf_pkg::DIFF_W'(sel_z) - mmuf_pkg::DIFF_W'(s1_y_next);
        s1_dm_next = mmuf_pkg::DIFF_W'(s1_y_next) - mmuf_pkg::DIFF_W'(sel_x);
    end

    always_comb
    begin
        s2_dp_next = mmuf_pkg::minmod(s1_dp_reg, mmuf_pkg::SLOPE_W'(s1_dm_reg) <<< 2);
        s2_dm_next = mmuf_pkg::minmod(s1_dm_reg, mmuf_pkg::SLOPE_W'(s1_dp_reg) <<< 2);
    end

    // offset the halved correction so the divider sees an unsigned word
    always_comb
    begin
        sum6      = mmuf_pkg::SUM_W'(s2_dm_reg) + (mmuf_pkg::SUM_W'(s2_dp_reg) <<< 1)
                    + mmuf_pkg::ROUND_SIX;
        half6     = sum6[mmuf_pkg::SUM_W-1:1];
        s3_u_next = {half6[mmuf_pkg::HALF_W-1], half6} + mmuf_pkg::U_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_dp_reg <= s1_dp_next;
            s1_dm_reg <= s1_dm_next;
            s1_y_reg  <= s1_y_next;
            s1_uf_reg <= face_velocity;
        end
        if (adv2)
        begin
            s2_dp_reg <= s2_dp_next;
            s2_dm_reg <= s2_dm_next;
            s2_y_reg  <= s1_y_reg;
            s2_uf_reg <= s1_uf_reg;
        end
        if (adv3)
        begin
            s3_u_reg  <= s3_u_next;
            s3_y_reg  <= s2_y_reg;
            s3_uf_reg <= s2_uf_reg;
        end
    end

    assign out_valid   = s3_valid_reg;
    assign out_word.u  = s3_u_reg;
    assign out_word.y  = s3_y_reg;
    assign out_word.uf = s3_uf_reg;

endmodule

[rtl/mmuf_div3.sv]
module mmuf_div3 (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mmuf_pkg::slope_word_t in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mmuf_pkg::quot_word_t  out_word
);

    localparam int NS  = mmuf_pkg::DIV_STAGES;
    localparam int DPS = mmuf_pkg::DIGITS_PER_STAGE;

    logic                     adv       [NS];
    logic                     valid_reg [NS];
    logic                     valid_in  [NS];
    logic [mmuf_pkg::U_W-1:0] work_reg  [NS];
    logic [mmuf_pkg::U_W-1:0] work_in   [NS];
    logic [mmuf_pkg::U_W-1:0] work_next [NS];
    logic [1:0]               rem_reg   [NS-1];
    logic [1:0]               rem_in    [NS];
    logic [1:0]               rem_out   [NS];
    mmuf_pkg::data_t          y_reg     [NS];
    mmuf_pkg::data_t          y_in      [NS];
    mmuf_pkg::data_t          uf_reg    [NS];
    mmuf_pkg::data_t          uf_in     [NS];

    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--)
            adv[s] = !valid_reg[s] || adv[s+1];
    end

    assign in_ready = adv[0];

    always_comb
    begin
        valid_in[0] = in_valid;
        work_in[0]  = in_word.u;
        rem_in[0]   = 2'd0;
        y_in[0]     = in_word.y;
        uf_in[0]    = in_word.uf;
        for (int s = 1; s < NS; s++)
        begin
            valid_in[s] = valid_reg[s-1];
            work_in[s]  = work_reg[s-1];
            rem_in[s]   = rem_reg[s-1];
            y_in[s]     = y_reg[s-1];
            uf_in[s]    = uf_reg[s-1];
        end
    end

    // long division from the top digit; quotient digits replace dividend digits
    always_comb
    begin : div_steps
        logic [mmuf_pkg::U_W-1:0] w;
        logic [1:0]               r;
        logic [3:0]               qr;
        for (int s = 0; s < NS; s++)
        begin
            w = work_in[s];
            r = rem_in[s];
            for (int j = 0; j < DPS; j++)
            begin
                qr = mmuf_pkg::div3_digit(r,
                         w[2*(mmuf_pkg::DIV_DIGITS-1-s*DPS-j) +: 2]);
                w[2*(mmuf_pkg::DIV_DIGITS-1-s*DPS-j) +: 2] = qr[3:2];
                r = qr[1:0];
            end
            work_next[s] = w;
            rem_out[s]   = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
                if (adv[s])
                    valid_reg[s] <= valid_in[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            if (adv[s])
            begin
                work_reg[s] <= work_next[s];
                y_reg[s]    <= y_in[s];
                uf_reg[s]   <= uf_in[s];
            end
        end
        for (int s = 0; s < NS - 1; s++)
            if (adv[s])
                rem_reg[s] <= rem_out[s];
    end

    assign out_valid   = valid_reg[NS-1];
    assign out_word.q  = work_reg[NS-1];
    assign out_word.y  = y_reg[NS-1];
    assign out_word.uf = uf_reg[NS-1];

endmodule

[rtl/mmuf_flux.sv]
module mmuf_flux (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mmuf_pkg::quot_word_t in_word,
    output logic                 flux_valid,
    input  logic                 flux_stall,
    output mmuf_pkg::data_t      face_flux,
    output logic                 saturated
);

    logic adv1, adv2, adv3;

    logic            f1_valid_reg, f2_valid_reg, f3_valid_reg;
    mmuf_pkg::data_t f1_phi_reg, f1_phi_next, f1_uf_reg;
    logic signed [mmuf_pkg::PROD_W-1:0] f2_prod_reg, f2_prod_next;
    mmuf_pkg::data_t f3_flux_reg, f3_flux_next;
    logic            f3_sat_reg, f3_sat_next;

    logic signed [mmuf_pkg::PHI_W-1:0]   phi_sum;
    logic signed [mmuf_pkg::RND_W-1:0]   rnd;
    logic signed [mmuf_pkg::SHIFT_W-1:0] shifted;
    logic [mmuf_pkg::SHIFT_W-mmuf_pkg::DATA_W:0] top_bits;

    assign adv3     = !f3_valid_reg || !flux_stall;
    assign adv2     = !f2_valid_reg || adv3;
    assign adv1     = !f1_valid_reg || adv2;
    assign in_ready = adv1;

    // drop the divider offset and add back the cell value
    always_comb
    begin
        phi_sum     = mmuf_pkg::PHI_W'(in_word.y) + $signed({1'b0, in_word.q})
                      - mmuf_pkg::Q_OFFSET;
        f1_phi_next = phi_sum[mmuf_pkg::DATA_W-1:0];
    end

    assign f2_prod_next = f1_uf_reg * f1_phi_reg;

    // round to nearest, ties upward, then clip to the word range
    always_comb
    begin
        rnd      = mmuf_pkg::RND_W'(f2_prod_reg) + mmuf_pkg::ROUND_HALF;
        shifted  = rnd[mmuf_pkg::RND_W-1:mmuf_pkg::FRAC_BITS];
        top_bits = shifted[mmuf_pkg::SHIFT_W-1:mmuf_pkg::DATA_W-1];
        if ((top_bits == '0) || (top_bits == '1))
        begin
            f3_flux_next = shifted[mmuf_pkg::DATA_W-1:0];
            f3_sat_next  = 1'b0;
        end
        else
        begin
            f3_flux_next = shifted[mmuf_pkg::SHIFT_W-1] ? mmuf_pkg::DATA_MIN
                                                        : mmuf_pkg::DATA_MAX;
            f3_sat_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                f1_valid_reg <= in_valid;
            if (adv2)
                f2_valid_reg <= f1_valid_reg;
            if (adv3)
                f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            f1_phi_reg <= f1_phi_next;
            f1_uf_reg  <= in_word.uf;
        end
        if (adv2)
            f2_prod_reg <= f2_prod_next;
        if (adv3)
        begin
            f3_flux_reg <= f3_flux_next;
            f3_sat_reg  <= f3_sat_next;
        end
    end

    assign flux_valid = f3_valid_reg;
    assign face_flux  = f3_flux_reg;
    assign saturated  = f3_sat_reg;

endmodule

[verif/muscl_minmod_upwind_face_flux_core_tb.sv]
module muscl_minmod_upwind_face_flux_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CYCLE_LIMIT = 400_000;
    localparam int              TAIL_CYCLES = 20;
    localparam longint          FLUX_HI     = 64'sd2147483647;
    localparam longint          FLUX_LO     = -FLUX_HI - 1;
    localparam mmuf_pkg::data_t Q_ONE       = 32'sh0001_0000;

    typedef struct packed {
        mmuf_pkg::data_t flux;
        logic            sat;
    } flux_word_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cell_valid;
    logic            cell_stall;
    mmuf_pkg::data_t cell_a;
    mmuf_pkg::data_t cell_b;
    mmuf_pkg::data_t cell_c;
    mmuf_pkg::data_t cell_d;
    mmuf_pkg::data_t face_velocity;
    logic            flux_valid;
    logic            flux_stall;
    mmuf_pkg::data_t face_flux;
    logic            saturated;

    flux_word_t flux_expect_q[$];
    int         flux_errors = 0;
    int         cycle_count = 0;
    bit         tx_idling   = 1'b1;
    bit         rx_idling   = 1'b1;
    int         rx_hold     = 0;

    muscl_minmod_upwind_face_flux_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_valid    (cell_valid),
        .cell_stall    (cell_stall),
        .cell_a        (cell_a),
        .cell_b        (cell_b),
        .cell_c        (cell_c),
        .cell_d        (cell_d),
        .face_velocity (face_velocity),
        .flux_valid    (flux_valid),
        .flux_stall    (flux_stall),
        .face_flux     (face_flux),
        .saturated     (saturated)
    );

    always #6 clk = ~clk;

    // minmod: zero unless both slopes share a sign, else the smaller magnitude
    function automatic longint slope_limit(input longint x, input longint y);
        longint m;
        if (x == 0)
            return 0;
        if (x > 0)
        begin
            m = (x < y) ? x : y;
            return (m > 0) ? m : 0;
        end
        m = (-x < -y) ? -x : -y;
        return (m > 0) ? -m : 0;
    endfunction

    function automatic longint div6_floor(input longint n);
        if (n >= 0)
            return n / 6;
        return -((-n + 5) / 6);
    endfunction

    function automatic longint left_face_state(input longint a, input longint b,
                                               input longint c);
        longint dp, dm, sp, sm;
        dp = c - b;
        dm = b - a;
        sp = slope_limit(dp, 4 * dm);
        sm = slope_limit(dm, 4 * dp);
        return div6_floor(6 * b + sm + 2 * sp + 3);
    endfunction

    function automatic longint right_face_state(input longint b, input longint c,
                                                input longint d);
        longint dp, dm, sp, sm;
        dp = d - c;
        dm = c - b;
        sp = slope_limit(dp, 4 * dm);
        sm = slope_limit(dm, 4 * dp);
        return div6_floor(6 * c - sp - 2 * sm + 3);
    endfunction

    function automatic flux_word_t upwind_flux(input mmuf_pkg::data_t a,
                                               input mmuf_pkg::data_t b,
                                               input mmuf_pkg::data_t c,
                                               input mmuf_pkg::data_t d,
                                               input mmuf_pkg::data_t uf);
        longint     phi, prod, f;
        flux_word_t w;
        phi = (uf >= 0) ? left_face_state(longint'(a), longint'(b), longint'(c))
                        : right_face_state(longint'(b), longint'(c), longint'(d));
        prod = longint'(uf) * phi;
        // round to nearest, ties upward; arithmetic shift floors
        f = (prod + (longint'(1) << (mmuf_pkg::FRAC_BITS - 1))) >>> mmuf_pkg::FRAC_BITS;
        w.sat = 1'b0;
        if (f > FLUX_HI)
        begin
            f = FLUX_HI;
            w.sat = 1'b1;
        end
        else if (f < FLUX_LO)
        begin
            f = FLUX_LO;
            w.sat = 1'b1;
        end
        w.flux = mmuf_pkg::data_t'(f);
        return w;
    endfunction

    function automatic mmuf_pkg::data_t corner_value();
        case ($urandom_range(0, 6))
            0: return mmuf_pkg::DATA_MIN;
            1: return mmuf_pkg::DATA_MAX;
            2: return '0;
            3: return mmuf_pkg::data_t'(1);
            4: return mmuf_pkg::data_t'(-1);
            5: return mmuf_pkg::DATA_MIN + 1;
            default: return mmuf_pkg::DATA_MAX - 1;
        endcase
    endfunction

    function automatic mmuf_pkg::data_t near_zero(input int span);
        return mmuf_pkg::data_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // hold the word until it is taken, then record its flux
    task automatic send_face(input mmuf_pkg::data_t a, input mmuf_pkg::data_t b,
                             input mmuf_pkg::data_t c, input mmuf_pkg::data_t d,
                             input mmuf_pkg::data_t uf);
        int gap;
        gap = 0;
        if (tx_idling && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_a        <= a;
        cell_b        <= b;
        cell_c        <= c;
        cell_d        <= d;
        face_velocity <= uf;
        cell_valid    <= 1'b1;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        flux_expect_q.push_back(upwind_flux(a, b, c, d, uf));
    endtask

    task automatic wait_all_fluxes();
        cell_valid <= 1'b0;
        do
            @(posedge clk);
        while (flux_expect_q.size() != 0);
    endtask

    task automatic send_random_face();
        mmuf_pkg::data_t a, b, c, d, uf, base, alt;
        int              step;
        base = corner_value();
        alt  = mmuf_pkg::data_t'($urandom);
        step = int'($urandom_range(0, 16383)) - 8192;
        case ($urandom_range(0, 5))
            0:
            begin
                a = mmuf_pkg::data_t'($urandom);
                b = mmuf_pkg::data_t'($urandom);
                c = mmuf_pkg::data_t'($urandom);
                d = mmuf_pkg::data_t'($urandom);
            end
            1:
            begin
                // smooth ramp with jitter
                if ($urandom_range(0, 1))
                    base = near_zero(1 << 24);
                a = base;
                b = a + mmuf_pkg::data_t'(step) + near_zero(64);
                c = b + mmuf_pkg::data_t'(step) + near_zero(64);
                d = c + mmuf_pkg::data_t'(step) + near_zero(64);
            end
            2:
            begin
                // plateaus and steps: equal neighbours zero a slope
                alt = near_zero(1 << 20);
                a = $urandom_range(0, 1) ? alt : alt + mmuf_pkg::data_t'(step);
                b = $urandom_range(0, 1) ? a : alt;
                c = $urandom_range(0, 1) ? b : alt + mmuf_pkg::data_t'(step);
                d = $urandom_range(0, 1) ? c : alt;
            end
            3:
            begin
                // local extremum at b or c
                alt = near_zero(1 << 22);
                a = alt;
                b = alt + mmuf_pkg::data_t'(step * 3);
                c = alt + near_zero(4096);
                d = c + mmuf_pkg::data_t'(step * 2);
            end
            4:
            begin
                a = near_zero(1 << 18);
                b = near_zero(1 << 18);
                c = near_zero(1 << 18);
                d = near_zero(1 << 18);
            end
            default:
            begin
                a = corner_value();
                b = corner_value();
                c = $urandom_range(0, 1) ? corner_value() : mmuf_pkg::data_t'($urandom);
                d = corner_value();
            end
        endcase
        case ($urandom_range(0, 6))
            0: uf = '0;
            1: uf = mmuf_pkg::data_t'($urandom);
            2, 3: uf = near_zero(1 << 18);
            4: uf = corner_value();
            5: uf = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
            default: uf = near_zero(1 << 26);
        endcase
        send_face(a, b, c, d, uf);
    endtask

    task automatic test_directed_faces();
        send_face('0, '0, '0, '0, '0);
        send_face(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, '0);
        // linear ramp, both upwind directions
        send_face(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, Q_ONE);
        send_face(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, -Q_ONE);
        // peak at b, then at c: limiter flattens the upwind state
        send_face('0, 5 * Q_ONE, Q_ONE, 2 * Q_ONE, 32'sh0001_8000);
        send_face('0, Q_ONE, 5 * Q_ONE, 2 * Q_ONE, -32'sh0001_8000);
        // flat field and steps
        send_face(3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE);
        send_face('0, '0, 10 * Q_ONE, 10 * Q_ONE, Q_ONE);
        send_face('0, '0, 10 * Q_ONE, 10 * Q_ONE, -Q_ONE);
        // steep slopes: first face caps its right slope at four times the left
        send_face('0, Q_ONE, 100 * Q_ONE, 101 * Q_ONE, Q_ONE);
        send_face(-100 * Q_ONE, -Q_ONE, '0, Q_ONE, -Q_ONE);
        // clipping in both directions for both velocity signs
        send_face(mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MAX,
                  mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MAX);
        send_face(mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MIN,
                  mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MAX);
        send_face(mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MIN,
                  mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MIN);
        send_face(mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MAX,
                  mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MIN);
        // flux rounding ties
        send_face(32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, mmuf_pkg::data_t'(1));
        send_face(32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, mmuf_pkg::data_t'(-1));
        // state rounding ties, positive and negative
        send_face('0, mmuf_pkg::data_t'(1), mmuf_pkg::data_t'(2),
                  mmuf_pkg::data_t'(3), Q_ONE);
        send_face('0, mmuf_pkg::data_t'(-1), mmuf_pkg::data_t'(-2),
                  mmuf_pkg::data_t'(-3), Q_ONE);
        send_face(mmuf_pkg::data_t'(3), mmuf_pkg::data_t'(2), mmuf_pkg::data_t'(1),
                  '0, -Q_ONE);
        // widest differences
        send_face(mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MIN,
                  mmuf_pkg::DATA_MAX, Q_ONE);
        send_face(mmuf_pkg::DATA_MAX, mmuf_pkg::DATA_MIN, mmuf_pkg::DATA_MAX,
                  mmuf_pkg::DATA_MIN, -Q_ONE);
        send_face(32'sh5555_AAAA, 32'shAAAA_5555, 32'sh0F0F_F0F0, 32'shF0F0_0F0F,
                  32'sh3C3C_C3C3);
    endtask

    task automatic test_random_faces(input int count);
        repeat (count) send_random_face();
    endtask

    // receiver holds off while the sender keeps offering: the pipe fills
    task automatic test_output_backpressure();
        tx_idling = 1'b0;
        rx_hold   = 200;
        repeat (60) send_random_face();
        tx_idling = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (40) send_random_face();
        wait_all_fluxes();
        repeat (40) send_random_face();
    endtask

    task automatic test_unthrottled_stream(input int count);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        repeat (count) send_random_face();
    endtask

    initial
    begin : rx_side
        bit stall_now;
        int rx_left;
        rx_left = 0;
        flux_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                flux_stall <= 1'b1;
                rx_hold--;
                rx_left = 0;
            end
            else if (rx_left > 0 && rx_idling)
                rx_left--;
            else
            begin
                stall_now = rx_idling && ($urandom_range(0, 2) == 0);
                flux_stall <= stall_now;
                rx_left = stall_now ? $urandom_range(0, 15) : $urandom_range(0, 30);
            end
        end
    end

    always @(posedge clk)
    begin : flux_check
        flux_word_t want;
        if (flux_valid && !flux_stall)
        begin
            if (flux_expect_q.size() == 0)
            begin
                if (flux_errors < 10)
                    $display("unexpected flux word %h saturated %b", face_flux, saturated);
                flux_errors++;
            end
            else
            begin
                want = flux_expect_q.pop_front();
                if (face_flux !== want.flux || saturated !== want.sat)
                begin
                    if (flux_errors < 10)
                        $display("flux mismatch: expected %h saturated %b, got %h saturated %b",
                                 want.flux, want.sat, face_flux, saturated);
                    flux_errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cell_valid    <= 1'b0;
        cell_a        <= '0;
        cell_b        <= '0;
        cell_c        <= '0;
        cell_d        <= '0;
        face_velocity <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_faces();
        test_random_faces(1500);
        test_output_backpressure();
        test_drain_pause();
        test_unthrottled_stream(250);

        wait_all_fluxes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (flux_errors == 0 && flux_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/mmuf_pkg.sv
rtl/mmuf_slope.sv
rtl/mmuf_div3.sv
rtl/mmuf_flux.sv
rtl/muscl_minmod_upwind_face_flux_core.sv
verif/muscl_minmod_upwind_face_flux_core_tb.sv
